FILE: rtl/core/gdfs_pkg.sv
package gdfs_pkg;

	localparam int NODES     = 64;
	localparam int STACK_CAP = 64;
	localparam int ID_W      = 6;
	localparam int LINK_W    = 7;
	localparam int CNT_W     = 7;
	localparam int SP_W      = $clog2(STACK_CAP);
	localparam int N_DIR     = 4;

	localparam logic [CNT_W-1:0] NODES_V = CNT_W'(NODES);
	localparam logic [CNT_W-1:0] STACK_V = CNT_W'(STACK_CAP);

	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} link_t;

	typedef link_t [N_DIR-1:0] row_t;

	typedef struct packed {
		logic [1:0]      dir;
		logic [ID_W-1:0] node;
	} stk_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_INS_RD,
		DP_INS_WR,
		DP_QSTART,
		DP_LNK_RD,
		DP_EXPLORE,
		DP_POP_LD,
		DP_FIN_WR,
		DP_OUT_RD,
		DP_OUT_HIT,
		DP_OUT_MISS,
		DP_OUT_NEXT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic start_ok;
		logic start_is_tgt;
		logic ex_exhaust;
		logic ex_hit;
		logic ex_descend;
		logic depth_one;
		logic out_last;
	} sts_t;

	function automatic logic link_ok(input logic [LINK_W-1:0] raw);
		return !raw[LINK_W-1] && ({1'b0, raw[ID_W-1:0]} < NODES_V);
	endfunction

endpackage

FILE: rtl/core/gdfs_datapath.sv
module gdfs_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gdfs_pkg::cmd_t             cmd,
	output gdfs_pkg::sts_t             sts,
	input  logic                       kind,
	input  logic [gdfs_pkg::ID_W-1:0]  node_id,
	input  logic [gdfs_pkg::LINK_W-1:0] north_link,
	input  logic [gdfs_pkg::LINK_W-1:0] east_link,
	input  logic [gdfs_pkg::LINK_W-1:0] south_link,
	input  logic [gdfs_pkg::LINK_W-1:0] west_link,
	input  logic [gdfs_pkg::ID_W-1:0]  target_id,
	output logic [gdfs_pkg::ID_W-1:0]  path_node,
	output logic                       found,
	output logic                       last
);

	// captured item
	logic                                         kind_q;
	logic [gdfs_pkg::ID_W-1:0]                    node_q;
	logic [gdfs_pkg::ID_W-1:0]                    tgt_q;
	logic [gdfs_pkg::N_DIR-1:0][gdfs_pkg::LINK_W-1:0] links_q;

	// graph and search state
	logic [gdfs_pkg::NODES-1:0]  present_q;
	logic [gdfs_pkg::NODES-1:0]  row_valid_q;
	logic [gdfs_pkg::NODES-1:0]  visited_q;
	logic [gdfs_pkg::ID_W-1:0]   top_q;
	logic [2:0]                  dir_q;
	logic [gdfs_pkg::CNT_W-1:0]  depth_q;
	logic [gdfs_pkg::CNT_W-1:0]  idx_q;

	logic [gdfs_pkg::ID_W-1:0]   out_node_q;
	logic                        out_found_q;
	logic                        out_last_q;

	// memories
	gdfs_pkg::row_t link_mem [gdfs_pkg::NODES];
	gdfs_pkg::stk_t stack_mem [gdfs_pkg::STACK_CAP];
	gdfs_pkg::row_t link_rd_s1;
	logic           rowv_s1;
	gdfs_pkg::stk_t stk_rd_s1;

	logic [gdfs_pkg::ID_W-1:0]   link_ra;
	logic                        link_re;
	gdfs_pkg::row_t              row_new;
	logic [gdfs_pkg::N_DIR-1:0]  new_ok;
	logic                        ins_ok;
	logic                        ins_we;
	logic [gdfs_pkg::NODES-1:0]  start_mask;
	logic [gdfs_pkg::NODES-1:0]  ins_mask;

	gdfs_pkg::link_t             lane;
	logic                        lane_ok;
	logic                        ex_exhaust;
	logic                        ex_hit;
	logic                        ex_descend;
	logic                        ex_push;

	logic                        stk_we;
	logic [gdfs_pkg::SP_W-1:0]   stk_wa;
	gdfs_pkg::stk_t              stk_wd;
	logic                        stk_re;
	logic [gdfs_pkg::SP_W-1:0]   stk_ra;
	logic [gdfs_pkg::CNT_W-1:0]  depth_m1;
	logic [gdfs_pkg::CNT_W-1:0]  depth_m2;

	assign depth_m1 = depth_q - gdfs_pkg::CNT_W'(1);
	assign depth_m2 = depth_q - gdfs_pkg::CNT_W'(2);

	// insert merge
	assign ins_ok = {1'b0, node_q} < gdfs_pkg::NODES_V;
	assign ins_we = (cmd.op == gdfs_pkg::DP_INS_WR) && ins_ok;

	always_comb begin
		for (int d = 0; d < gdfs_pkg::N_DIR; d++) begin
			new_ok[d] = gdfs_pkg::link_ok(links_q[d]);
			if (new_ok[d]) begin
				row_new[d].valid = 1'b1;
				row_new[d].id    = links_q[d][gdfs_pkg::ID_W-1:0];
			end else if (rowv_s1) begin
				row_new[d] = link_rd_s1[d];
			end else begin
				row_new[d].valid = 1'b0;
				row_new[d].id    = '0;
			end
		end
	end

	always_comb begin
		start_mask         = '0;
		start_mask[node_q] = 1'b1;
		ins_mask           = start_mask;
		for (int d = 0; d < gdfs_pkg::N_DIR; d++) begin
			if (new_ok[d]) begin
				ins_mask[links_q[d][gdfs_pkg::ID_W-1:0]] = 1'b1;
			end
		end
	end

	// explore step on the current link
	assign lane       = link_rd_s1[dir_q[1:0]];
	assign lane_ok    = rowv_s1 && lane.valid;
	assign ex_exhaust = dir_q[2];
	assign ex_hit     = !ex_exhaust && lane_ok && (lane.id == tgt_q);
	assign ex_descend = !ex_exhaust && lane_ok && (lane.id != tgt_q) && !visited_q[lane.id];
	assign ex_push    = (cmd.op == gdfs_pkg::DP_EXPLORE) && (ex_hit || ex_descend);

	assign link_re = (cmd.op == gdfs_pkg::DP_INS_RD) || (cmd.op == gdfs_pkg::DP_LNK_RD);
	assign link_ra = (cmd.op == gdfs_pkg::DP_INS_RD) ? node_q : top_q;

	always_comb begin
		stk_we = ex_push || (cmd.op == gdfs_pkg::DP_FIN_WR);
		stk_wa = depth_m1[gdfs_pkg::SP_W-1:0];
		stk_wd.node = top_q;
		stk_wd.dir  = (cmd.op == gdfs_pkg::DP_FIN_WR) ? 2'd0 : dir_q[1:0];
		stk_re = ((cmd.op == gdfs_pkg::DP_EXPLORE) && ex_exhaust) ||
		         (cmd.op == gdfs_pkg::DP_OUT_RD);
		stk_ra = (cmd.op == gdfs_pkg::DP_OUT_RD) ? idx_q[gdfs_pkg::SP_W-1:0]
		                                          : depth_m2[gdfs_pkg::SP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ins_we) begin
			link_mem[node_q] <= row_new;
		end
		if (link_re) begin
			link_rd_s1 <= link_mem[link_ra];
			rowv_s1    <= row_valid_q[link_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_s1 <= stack_mem[stk_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == gdfs_pkg::DP_LOAD) begin
			kind_q     <= kind;
			node_q     <= node_id;
			tgt_q      <= target_id;
			links_q[0] <= north_link;
			links_q[1] <= east_link;
			links_q[2] <= south_link;
			links_q[3] <= west_link;
		end
		if (cmd.op == gdfs_pkg::DP_OUT_HIT) begin
			out_node_q <= stk_rd_s1.node;
		end else if (cmd.op == gdfs_pkg::DP_OUT_MISS) begin
			out_node_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			row_valid_q <= '0;
			visited_q   <= '0;
			top_q       <= '0;
			dir_q       <= '0;
			depth_q     <= '0;
			idx_q       <= '0;
			out_found_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			unique case (cmd.op)
				gdfs_pkg::DP_INS_WR: begin
					if (ins_ok) begin
						row_valid_q[node_q] <= 1'b1;
						present_q           <= present_q | ins_mask;
					end
				end
				gdfs_pkg::DP_QSTART: begin
					visited_q <= start_mask;
					top_q     <= node_q;
					dir_q     <= '0;
					depth_q   <= gdfs_pkg::CNT_W'(1);
				end
				gdfs_pkg::DP_EXPLORE: begin
					if (ex_exhaust) begin
						depth_q <= depth_m1;
					end else if (ex_hit) begin
						top_q   <= lane.id;
						depth_q <= depth_q + gdfs_pkg::CNT_W'(1);
					end else if (ex_descend) begin
						visited_q[lane.id] <= 1'b1;
						top_q   <= lane.id;
						dir_q   <= '0;
						depth_q <= depth_q + gdfs_pkg::CNT_W'(1);
					end else begin
						dir_q <= dir_q + 3'd1;
					end
				end
				gdfs_pkg::DP_POP_LD: begin
					top_q <= stk_rd_s1.node;
					dir_q <= {1'b0, stk_rd_s1.dir} + 3'd1;
				end
				gdfs_pkg::DP_FIN_WR: begin
					idx_q <= '0;
				end
				gdfs_pkg::DP_OUT_HIT: begin
					out_found_q <= 1'b1;
					out_last_q  <= (idx_q + gdfs_pkg::CNT_W'(1)) == depth_q;
				end
				gdfs_pkg::DP_OUT_MISS: begin
					out_found_q <= 1'b0;
					out_last_q  <= 1'b1;
				end
				gdfs_pkg::DP_OUT_NEXT: begin
					idx_q <= idx_q + gdfs_pkg::CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		sts.kind         = kind_q;
		sts.start_ok     = ({1'b0, node_q} < gdfs_pkg::NODES_V) && present_q[node_q];
		sts.start_is_tgt = node_q == tgt_q;
		sts.ex_exhaust   = ex_exhaust;
		sts.ex_hit       = ex_hit;
		sts.ex_descend   = ex_descend;
		sts.depth_one    = depth_q == gdfs_pkg::CNT_W'(1);
		sts.out_last     = out_last_q;
	end

	assign path_node = out_node_q;
	assign found     = out_found_q;
	assign last      = out_last_q;

`ifndef SYNTHESIS
	a_depth_cap: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= gdfs_pkg::STACK_V)
		else $error("path depth beyond stack capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ex_push |-> depth_q < gdfs_pkg::STACK_V)
		else $error("push into a full stack");

	a_top_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == gdfs_pkg::DP_EXPLORE) |-> visited_q[top_q])
		else $error("exploring a node not marked visited");

	a_out_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == gdfs_pkg::DP_OUT_RD) |-> (idx_q < depth_q))
		else $error("path read beyond depth");
`endif

endmodule

FILE: rtl/core/gdfs_ctrl.sv
module gdfs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  gdfs_pkg::sts_t sts,
	output gdfs_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INS_WR,
		ST_LNK_RD,
		ST_EXPLORE,
		ST_POP_LD,
		ST_FIN_WR,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_MISS,
		ST_OUT_WAIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = gdfs_pkg::DP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = gdfs_pkg::DP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (!sts.kind) begin
					cmd.op  = gdfs_pkg::DP_INS_RD;
					state_d = ST_INS_WR;
				end else if (sts.start_ok) begin
					cmd.op  = gdfs_pkg::DP_QSTART;
					state_d = sts.start_is_tgt ? ST_FIN_WR : ST_LNK_RD;
				end else begin
					state_d = ST_OUT_MISS;
				end
			end
			ST_INS_WR: begin
				cmd.op  = gdfs_pkg::DP_INS_WR;
				state_d = ST_IDLE;
			end
			ST_LNK_RD: begin
				cmd.op  = gdfs_pkg::DP_LNK_RD;
				state_d = ST_EXPLORE;
			end
			ST_EXPLORE: begin
				cmd.op = gdfs_pkg::DP_EXPLORE;
				priority if (sts.ex_exhaust) begin
					state_d = sts.depth_one ? ST_OUT_MISS : ST_POP_LD;
				end else if (sts.ex_hit) begin
					state_d = ST_FIN_WR;
				end else if (sts.ex_descend) begin
					state_d = ST_LNK_RD;
				end else begin
					state_d = ST_EXPLORE;
				end
			end
			ST_POP_LD: begin
				cmd.op  = gdfs_pkg::DP_POP_LD;
				state_d = ST_LNK_RD;
			end
			ST_FIN_WR: begin
				cmd.op  = gdfs_pkg::DP_FIN_WR;
				state_d = ST_OUT_RD;
			end
			ST_OUT_RD: begin
				cmd.op  = gdfs_pkg::DP_OUT_RD;
				state_d = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				cmd.op  = gdfs_pkg::DP_OUT_HIT;
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_MISS: begin
				cmd.op  = gdfs_pkg::DP_OUT_MISS;
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (out_ready) begin
					if (sts.out_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.op  = gdfs_pkg::DP_OUT_NEXT;
						state_d = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			in_ready_q  <= state_d == ST_IDLE;
			out_valid_q <= state_d == ST_OUT_WAIT;
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/grid_graph_dfs_path_finder_top.sv
// Grid-graph path finder. Insert transfers (tuser = 0) load a node's north/east/south/west
// links. A query transfer (tuser = 1) clears the visited marks and runs a depth-first
// search from start to target, trying north, east, south, west; it then streams the path
// start first, one transfer per node with tuser (found) = 1 and tlast on the final node,
// or a single transfer with found = 0 when no path exists. The search reads a node's row
// from the single-port link table each time it enters or backtracks to that node, then
// tries its links in turn; each path node is read back from the stack, and the output
// waits while m_axis_tready is low. One item is handled at a time.
module grid_graph_dfs_path_finder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// node_id[5:0], north_link[12:6], east_link[19:13], south_link[26:20],
	// west_link[33:27], target_id[39:34]
	input  logic [39:0] s_axis_tdata,
	// kind[0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// path_node[5:0], zero[7:6]
	output logic [7:0]  m_axis_tdata,
	// found[0]
	output logic [0:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	gdfs_pkg::cmd_t            cmd;
	gdfs_pkg::sts_t            sts;
	logic [gdfs_pkg::ID_W-1:0] path_node;
	logic                      found;

	gdfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gdfs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (s_axis_tuser[0]),
		.node_id    (s_axis_tdata[5:0]),
		.north_link (s_axis_tdata[12:6]),
		.east_link  (s_axis_tdata[19:13]),
		.south_link (s_axis_tdata[26:20]),
		.west_link  (s_axis_tdata[33:27]),
		.target_id  (s_axis_tdata[39:34]),
		.path_node  (path_node),
		.found      (found),
		.last       (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, path_node};
	assign m_axis_tuser = found;

endmodule
